### src/lli_pkg.sv
package lli_pkg;

    // field widths of the command and result beats
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int IDX_W = 5;
    localparam int CFG_W = 6;

    // reset value of the points-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd2;

    // request codes; the fourth code has no meaning
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_FWD   = 2'd1,
        REQ_REV   = 2'd2
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_CLAMP = 2'd1,
        ST_NOSEG = 2'd2,
        ST_WRITE = 2'd3
    } status_t;

    // divider request: product over segment width
    typedef struct packed {
        logic                 start;
        logic [2*VAL_W-1:0]   dividend;
        logic [VAL_W-1:0]     divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic                 done;
        logic [VAL_W-1:0]     quot;
    } div_out_t;

endpackage

### src/lli_ram.sv
module lli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/lli_div.sv
module lli_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lli_pkg::div_req_t req,
    output lli_pkg::div_out_t rsp
);

    import lli_pkg::*;

    // quotient is known to fit in VAL_W bits, so only the low half is iterated
    localparam int STEP_W = $clog2(VAL_W);

    logic                 run_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    cnt_reg;
    logic [VAL_W-1:0]     rem_reg;
    logic [VAL_W-1:0]     quo_reg;
    logic [VAL_W-1:0]     dvs_reg;

    logic [VAL_W:0]       trial;
    logic [VAL_W:0]       diff;
    logic                 ge;

    // one restoring step: shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[VAL_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(VAL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[2*VAL_W-1:VAL_W];
            quo_reg <= req.dividend[VAL_W-1:0];
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

### src/lut_linear_interpolator.sv
// Piecewise-linear lookup table over (x,y) breakpoints, Q16.16 signed.
// Command channel: a beat is taken at a rising edge with start high and busy
// low. req_type selects a breakpoint write (point_index, point_x, point_y),
// a forward lookup (query is x, answer y) or a reverse lookup (query is y,
// answer x). Every beat gives exactly one result beat: done is high for one
// cycle with result_value and status; the receiver cannot stall it.
// Configuration: cfg_wr_en/cfg_wr_data set the number of breakpoints in use;
// write it only while idle.
// Flow: a write or an unused request code answers in the next cycle and
// busy stays low, so one beat per cycle. A lookup holds busy while it
// walks the table memory through its one read port, one entry per cycle:
// it reads the last entry in use first and answers a clamped key from it;
// with more entries in use it then scans up from entry 0 and ends at a
// breakpoint match, at the segment that holds the key (interpolated by the
// bit-serial divider) or at the last entry in use.
// Reset: control clears, points in use returns to 2. Table contents are not
// cleared; every entry must be written before a lookup can reach it.
module lut_linear_interpolator #(
    parameter int MAX_POINTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lli_pkg::REQ_W-1:0]           req_type,
    input  logic [lli_pkg::IDX_W-1:0]           point_index,
    input  logic signed [lli_pkg::VAL_W-1:0]    point_x,
    input  logic signed [lli_pkg::VAL_W-1:0]    point_y,
    input  logic signed [lli_pkg::VAL_W-1:0]    query,
    input  logic                                cfg_wr_en,
    input  logic [lli_pkg::CFG_W-1:0]           cfg_wr_data,
    output logic                                done,
    output logic signed [lli_pkg::VAL_W-1:0]    result_value,
    output logic [1:0]                          status
);

    import lli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LAST  = 6'b000010,
        S_FIRST = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MUL   = 6'b010000,
        S_DIV   = 6'b100000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic                      done_reg;
    logic [CFG_W-1:0]          cfg_reg;

    logic signed [VAL_W-1:0]   q_reg;
    logic                      rev_reg;
    logic [AW-1:0]             idx_reg;
    logic signed [VAL_W-1:0]   prev_key_reg;
    logic signed [VAL_W-1:0]   prev_val_reg;
    logic [VAL_W-1:0]          dq_reg;
    logic [VAL_W-1:0]          dk_reg;
    logic [VAL_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic signed [VAL_W-1:0]   v0_reg;
    logic signed [VAL_W-1:0]   result_reg;
    status_t                   status_reg;

    logic                      accept;
    logic [AW-1:0]             last_idx;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [2*VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0]   rd_x;
    logic signed [VAL_W-1:0]   rd_y;
    logic signed [VAL_W-1:0]   rd_key;
    logic signed [VAL_W-1:0]   rd_val;
    logic                      at_clamp;
    logic                      hit_eq;
    logic                      in_seg;
    logic [VAL_W:0]            dq_w;
    logic [VAL_W:0]            dk_w;
    logic [VAL_W:0]            dv_w;
    logic [VAL_W:0]            mag_w;
    logic [VAL_W:0]            sum_w;
    logic                      finish;
    logic signed [VAL_W-1:0]   fin_val;
    status_t                   fin_st;
    div_req_t                  div_req;
    div_out_t                  div_rsp;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // index of the last entry in use: zero acts as one, clamp to table size
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(cfg_reg) > MAX_POINTS)
        begin
            last_idx = AW'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = AW'(cfg_reg - CFG_W'(1));
        end
    end

    // breakpoint table, x in the upper half
    assign ram_we = accept && (req_type == REQ_WRITE) && (32'(point_index) < MAX_POINTS);

    lli_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata ({point_x, point_y}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // key and value of the entry just read, by lookup direction
    assign rd_x   = ram_rdata[2*VAL_W-1:VAL_W];
    assign rd_y   = ram_rdata[VAL_W-1:0];
    assign rd_key = rev_reg ? rd_y : rd_x;
    assign rd_val = rev_reg ? rd_x : rd_y;

    // segment tests: previous entry is the low end, current entry the high end
    assign at_clamp = (q_reg >= rd_key);
    assign hit_eq   = (q_reg == prev_key_reg);
    assign in_seg   = (q_reg > prev_key_reg) && (q_reg < rd_key);

    // segment setup: offsets are positive inside a segment
    assign dq_w  = {q_reg[VAL_W-1], q_reg} - {prev_key_reg[VAL_W-1], prev_key_reg};
    assign dk_w  = {rd_key[VAL_W-1], rd_key} - {prev_key_reg[VAL_W-1], prev_key_reg};
    assign dv_w  = {rd_val[VAL_W-1], rd_val} - {prev_val_reg[VAL_W-1], prev_val_reg};
    assign mag_w = dv_w[VAL_W] ? (~dv_w + (VAL_W+1)'(1)) : dv_w;

    // final add of the quotient onto the low-end value
    assign sum_w = neg_reg ? ({v0_reg[VAL_W-1], v0_reg} - {1'b0, div_rsp.quot})
                           : ({v0_reg[VAL_W-1], v0_reg} + {1'b0, div_rsp.quot});

    // product into the divider's input registers
    always_comb
    begin
        div_req.start    = (state_reg == S_MUL);
        div_req.dividend = mag_reg * dq_reg;
        div_req.divisor  = dk_reg;
    end

    lli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer: memory reads, scan decisions, result selection
    always_comb
    begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        finish     = 1'b0;
        fin_val    = '0;
        fin_st     = ST_NOSEG;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_WRITE:
                        begin
                            finish = 1'b1;
                            fin_st = ST_WRITE;
                        end
                        REQ_FWD, REQ_REV:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = last_idx;
                            state_next = S_LAST;
                        end
                        default:
                        begin
                            finish = 1'b1;
                            fin_st = ST_NOSEG;
                        end
                    endcase
                end
            end
            S_LAST:
            begin
                if (at_clamp)
                begin
                    finish     = 1'b1;
                    fin_val    = rd_val;
                    fin_st     = ST_CLAMP;
                    state_next = S_IDLE;
                end
                else if (last_idx == '0)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg + AW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit_eq)
                begin
                    finish     = 1'b1;
                    fin_val    = prev_val_reg;
                    fin_st     = ST_FOUND;
                    state_next = S_IDLE;
                end
                else if (in_seg)
                begin
                    state_next = S_MUL;
                end
                else if (idx_reg == last_idx)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    finish     = 1'b1;
                    fin_val    = sum_w[VAL_W-1:0];
                    fin_st     = ST_FOUND;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cfg_reg   <= CFG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // lookup working registers and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg   <= query;
            rev_reg <= (req_type == REQ_REV);
        end
        case (state_reg)
            S_LAST:
            begin
                idx_reg <= '0;
            end
            S_FIRST, S_SCAN:
            begin
                if (state_reg == S_SCAN && in_seg)
                begin
                    dq_reg  <= dq_w[VAL_W-1:0];
                    dk_reg  <= dk_w[VAL_W-1:0];
                    mag_reg <= mag_w[VAL_W-1:0];
                    neg_reg <= dv_w[VAL_W];
                    v0_reg  <= prev_val_reg;
                end
                else
                begin
                    prev_key_reg <= rd_key;
                    prev_val_reg <= rd_val;
                    idx_reg      <= idx_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (finish)
        begin
            result_reg <= fin_val;
            status_reg <= fin_st;
        end
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

### src/lli_checker.sv
module lli_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [lli_pkg::REQ_W-1:0]         req_type,
    input logic                              done,
    input logic signed [lli_pkg::VAL_W-1:0]  result_value,
    input logic [1:0]                        status
);

    import lli_pkg::*;

    // a taken write answers in the next cycle with a zero value
    a_write_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_WRITE)
        |=> (done && status == ST_WRITE && result_value == '0))
        else $error("write beat not answered next cycle");

    // a taken lookup holds off the next command
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_FWD || req_type == REQ_REV))
        |=> (busy && !done))
        else $error("lookup did not raise busy");

    // the end of a lookup comes with its result beat
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    // unused request code answers no-segment
    a_unused_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type != REQ_WRITE && req_type != REQ_FWD
            && req_type != REQ_REV)
        |=> (done && status == ST_NOSEG && result_value == '0))
        else $error("unused request code not answered as no segment");

    // a failed lookup carries a zero value
    a_noseg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NOSEG) |-> (result_value == '0))
        else $error("no-segment result with nonzero value");

endmodule

bind lut_linear_interpolator lli_checker u_lli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .done         (done),
    .result_value (result_value),
    .status       (status)
);
